[src/time_segment_table_macros.svh]
// Assertion macros for the time segment table.
// Included by the top level; needs nothing else.
`ifndef TIME_SEGMENT_TABLE_MACROS_SVH
`define TIME_SEGMENT_TABLE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on the rising clock edge outside reset.
`define TST_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("time_segment_table: same-cycle check failed");
// Next-cycle implication, checked on the rising clock edge outside reset.
`define TST_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("time_segment_table: next-cycle check failed");
`else
`define TST_ASSERT_IMP(label, clk, rst, ante, cons)
`define TST_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

[src/tst_pkg.sv]
// Shared types and constants for the time segment table.
// Used by tst_cell, tst_pick and time_segment_table; depends on nothing.
`default_nettype none

package tst_pkg;

   // Field widths fixed by the interface.
   localparam int TIME_W = 63;
   localparam int ID_W   = 32;
   localparam int POS_W  = 4;
   localparam int STAT_W = 3;
   localparam int FROM_W = 4;

   // Default table depth.
   localparam int MAX_SEGMENTS_DEF = 16;

   // Command codes.
   localparam logic CMD_ADD    = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   // Status codes.
   localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
   localparam logic [STAT_W-1:0] STAT_ORDER   = 3'd1;
   localparam logic [STAT_W-1:0] STAT_ZERO    = 3'd2;
   localparam logic [STAT_W-1:0] STAT_OVERLAP = 3'd3;
   localparam logic [STAT_W-1:0] STAT_FULL    = 3'd4;

   // One table entry.
   typedef struct packed {
      logic [TIME_W-1:0] seg_start;
      logic [TIME_W-1:0] seg_end;
      logic [ID_W-1:0]   seg_id;
   } entry_type;

   // A captured request.
   typedef struct packed {
      logic              cmd;
      logic [TIME_W-1:0] seg_start;
      logic [TIME_W-1:0] seg_end;
      logic [TIME_W-1:0] elapsed;
      logic [FROM_W-1:0] from_position;
   } req_type;

   // Per-cell compare outcome: ev marks the cell that ends the walk,
   // ok says whether an add may be placed in front of it.
   typedef struct packed {
      logic ev;
      logic ok;
   } flag_type;

   // Per-cell control from the top level.
   typedef struct packed {
      logic valid;
      logic scan;
      logic shift;
      logic load;
   } cell_ctl_type;

endpackage

`default_nettype wire

[src/tst_cell.sv]
// One cell of the segment chain: holds one entry and compares it with the request.
// Depends on tst_pkg.
`default_nettype none

module tst_cell (
   input  logic                  clock,
   input  tst_pkg::req_type      req,
   input  tst_pkg::cell_ctl_type ctl,
   input  tst_pkg::entry_type    prev_entry,
   input  tst_pkg::entry_type    new_entry,
   output tst_pkg::entry_type    entry,
   output tst_pkg::flag_type     flags
);

   tst_pkg::entry_type entry_ff;
   tst_pkg::entry_type entry_in;
   tst_pkg::flag_type  flags_ff;
   tst_pkg::flag_type  flags_in;

   logic es_zero;
   logic ee_zero;
   logic whole;
   logic stop;

   // Compare the stored entry with the request.
   always_comb begin
      es_zero  = (entry_ff.seg_start == '0);
      ee_zero  = (entry_ff.seg_end == '0);
      whole    = es_zero && ee_zero;
      stop     = 1'b0;
      flags_in = '0;
      if (req.cmd == tst_pkg::CMD_LOOKUP) begin
         flags_in.ev = ctl.valid && ctl.scan
                       && (es_zero || req.elapsed >= entry_ff.seg_start)
                       && (ee_zero || req.elapsed < entry_ff.seg_end);
         flags_in.ok = 1'b1;
      end else if (req.seg_start == '0) begin
         // Open start: the walking start is the end of the cell to the left.
         stop        = (prev_entry.seg_end == '0) && !es_zero;
         flags_in.ev = ctl.valid && (whole || stop || req.seg_end <= entry_ff.seg_end);
         flags_in.ok = stop && (req.seg_end < entry_ff.seg_start);
      end else begin
         // Bounded start: the first entry starting later takes it in front.
         stop        = !es_zero && (req.seg_start < entry_ff.seg_start);
         flags_in.ev = ctl.valid && (whole || stop || ee_zero
                                     || req.seg_start < entry_ff.seg_end);
         flags_in.ok = stop && ((req.seg_end == '0)
                                || req.seg_end <= entry_ff.seg_start);
      end
   end

   // Take the new entry, the neighbor's entry on a shift, or hold.
   always_comb begin
      priority if (ctl.load) begin
         entry_in = new_entry;
      end else if (ctl.shift) begin
         entry_in = prev_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      flags_ff <= flags_in;
   end

   assign entry = entry_ff;
   assign flags = flags_ff;

endmodule

`default_nettype wire

[src/tst_pick.sv]
// First-match selector: isolates the lowest flagged cell and returns its entry.
// Depends on tst_pkg.
`default_nettype none

module tst_pick #(
   parameter int N  = tst_pkg::MAX_SEGMENTS_DEF,
   parameter int IW = (N > 1) ? $clog2(N) : 1
) (
   input  logic [N-1:0]       vec,
   input  logic [N-1:0]       ok_vec,
   input  tst_pkg::entry_type entries [N],
   output logic               any,
   output logic [IW-1:0]      idx,
   output tst_pkg::entry_type sel,
   output logic               sel_ok
);

   logic [N-1:0] first;

   // Lowest set bit by two's complement, then an AND-OR select.
   always_comb begin
      first  = vec & (~vec + N'(1));
      any    = |vec;
      idx    = '0;
      sel    = '0;
      sel_ok = 1'b0;
      for (int i = 0; i < N; i++) begin
         if (first[i]) begin
            idx    = idx | IW'(i);
            sel    = sel | entries[i];
            sel_ok = sel_ok | ok_vec[i];
         end
      end
   end

endmodule

`default_nettype wire

[src/time_segment_table.sv]
// Time segment table: an ordered table of non-overlapping (start, end, id)
// segments held in a chain of cells, one entry per cell, where a time of 0
// means unbounded. An add places, adjusts and inserts a segment or rejects it
// with a status; a lookup returns the first segment at or after a position
// that contains the elapsed time. Each item passes through the states EVAL
// and RESOLVE after its transfer: in EVAL every cell compares its entry with
// the request in parallel, in RESOLVE the first flagged cell is selected, the
// result is formed and, on an add, the cells shift right by one behind the
// insertion point. A new item is taken in the cycle its predecessor's result
// is registered, not before. RESOLVE waits while the output stage is full.
// Depends on tst_pkg, tst_cell, tst_pick and time_segment_table_macros.svh.
`default_nettype none
`include "time_segment_table_macros.svh"

module time_segment_table #(
   parameter int MAX_SEGMENTS = tst_pkg::MAX_SEGMENTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_cmd,
   input  logic [tst_pkg::TIME_W-1:0]    req_seg_start_in,
   input  logic [tst_pkg::TIME_W-1:0]    req_seg_end_in,
   input  logic [tst_pkg::TIME_W-1:0]    req_elapsed,
   input  logic [tst_pkg::FROM_W-1:0]    req_from_position,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [tst_pkg::STAT_W-1:0]    rsp_status,
   output logic                          rsp_found,
   output logic [tst_pkg::POS_W-1:0]     rsp_position,
   output logic [tst_pkg::ID_W-1:0]      rsp_seg_id,
   output logic [tst_pkg::TIME_W-1:0]    rsp_seg_start,
   output logic [tst_pkg::TIME_W-1:0]    rsp_seg_end
);

   localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam int PW = tst_pkg::POS_W;
   localparam int DW = tst_pkg::ID_W;

   typedef enum logic [1:0] {IDLE, EVAL, RESOLVE} state_type;

   state_type                     state_ff;
   tst_pkg::req_type              req_ff;
   logic [CW-1:0]                 entry_count_ff;
   logic [DW-1:0]                 next_id_ff;
   logic                          order_ff;
   logic                          zero_ff;
   logic                          full_ff;

   logic                          rsp_valid_ff;
   logic [tst_pkg::STAT_W-1:0]    rsp_status_ff;
   logic                          rsp_found_ff;
   logic [PW-1:0]                 rsp_position_ff;
   logic [DW-1:0]                 rsp_seg_id_ff;
   logic [tst_pkg::TIME_W-1:0]    rsp_seg_start_ff;
   logic [tst_pkg::TIME_W-1:0]    rsp_seg_end_ff;

   tst_pkg::entry_type            cell_entry [MAX_SEGMENTS];
   tst_pkg::flag_type             cell_flag  [MAX_SEGMENTS];
   tst_pkg::cell_ctl_type         cell_ctl   [MAX_SEGMENTS];
   logic [MAX_SEGMENTS-1:0]       ev_vec;
   logic [MAX_SEGMENTS-1:0]       ok_vec;

   logic                          ev_any;
   logic [IW-1:0]                 ev_idx;
   tst_pkg::entry_type            ev_entry;
   logic                          ev_ok;

   logic [IW-1:0]                 last_idx;
   tst_pkg::entry_type            last_entry;

   logic                          out_free;
   logic                          resolve_go;
   logic                          accept;
   logic                          add_ok;
   logic                          do_insert;
   logic [tst_pkg::STAT_W-1:0]    res_status;
   logic                          res_found;
   logic [IW-1:0]                 res_pos;
   tst_pkg::entry_type            res_entry;

   // Handshake: a result can be registered when the output stage is free.
   always_comb begin
      out_free   = !rsp_valid_ff || rsp_ready;
      resolve_go = (state_ff == RESOLVE) && out_free;
      req_ready  = (state_ff == IDLE) || resolve_go;
      accept     = req_valid && req_ready;
   end

   // The chain of cells; each shifts in its left neighbor's entry.
   for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
      assign cell_ctl[i] = '{valid: (CW'(i) < entry_count_ff),
                             scan:  (i >= int'(req_ff.from_position)),
                             shift: do_insert && (IW'(i) > res_pos),
                             load:  do_insert && (IW'(i) == res_pos)};
      assign ev_vec[i] = cell_flag[i].ev;
      assign ok_vec[i] = cell_flag[i].ok;

      if (i == 0) begin : g_head
         tst_cell u_cell (
            .clock      (clock),
            .req        (req_ff),
            .ctl        (cell_ctl[i]),
            .prev_entry ('0),
            .new_entry  (res_entry),
            .entry      (cell_entry[i]),
            .flags      (cell_flag[i])
         );
      end else begin : g_body
         tst_cell u_cell (
            .clock      (clock),
            .req        (req_ff),
            .ctl        (cell_ctl[i]),
            .prev_entry (cell_entry[i-1]),
            .new_entry  (res_entry),
            .entry      (cell_entry[i]),
            .flags      (cell_flag[i])
         );
      end
   end

   // First cell that ends the walk or matches the lookup.
   tst_pick #(
      .N  (MAX_SEGMENTS),
      .IW (IW)
   ) u_pick (
      .vec     (ev_vec),
      .ok_vec  (ok_vec),
      .entries (cell_entry),
      .any     (ev_any),
      .idx     (ev_idx),
      .sel     (ev_entry),
      .sel_ok  (ev_ok)
   );

   // Tail entry, whose end becomes the start of an appended open-start segment.
   always_comb begin
      last_idx   = IW'(entry_count_ff - CW'(1));
      last_entry = cell_entry[last_idx];
   end

   // Form the result and the entry to insert.
   always_comb begin
      res_status = tst_pkg::STAT_OK;
      res_found  = 1'b0;
      res_pos    = '0;
      res_entry  = '0;
      add_ok     = 1'b0;
      if (req_ff.cmd == tst_pkg::CMD_LOOKUP) begin
         if (ev_any) begin
            res_found = 1'b1;
            res_pos   = ev_idx;
            res_entry = ev_entry;
         end
      end else begin
         priority if (order_ff) begin
            res_status = tst_pkg::STAT_ORDER;
         end else if (zero_ff) begin
            res_status = tst_pkg::STAT_ZERO;
         end else if (full_ff) begin
            res_status = tst_pkg::STAT_FULL;
         end else if (ev_any && !ev_ok) begin
            res_status = tst_pkg::STAT_OVERLAP;
         end else begin
            add_ok           = 1'b1;
            res_found        = 1'b1;
            res_pos          = ev_any ? ev_idx : IW'(entry_count_ff);
            res_entry.seg_id = next_id_ff;
            if (req_ff.seg_start != '0) begin
               res_entry.seg_start = req_ff.seg_start;
            end else if (!ev_any && entry_count_ff != '0) begin
               res_entry.seg_start = last_entry.seg_end;
            end else begin
               res_entry.seg_start = '0;
            end
            // An open end in front of a bounded entry is clipped to its start.
            if (ev_any && req_ff.seg_start != '0 && req_ff.seg_end == '0) begin
               res_entry.seg_end = ev_entry.seg_start;
            end else begin
               res_entry.seg_end = req_ff.seg_end;
            end
         end
      end
      do_insert = resolve_go && add_ok;
   end

   // Sequencer, request capture, table counters and output stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= IDLE;
         rsp_valid_ff   <= 1'b0;
         entry_count_ff <= '0;
         next_id_ff     <= '0;
      end else begin
         if (accept) begin
            req_ff <= '{cmd:           req_cmd,
                        seg_start:     req_seg_start_in,
                        seg_end:       req_seg_end_in,
                        elapsed:       req_elapsed,
                        from_position: req_from_position};
         end

         unique case (state_ff)
            IDLE: begin
               if (accept) begin
                  state_ff <= EVAL;
               end
            end
            EVAL: begin
               state_ff <= RESOLVE;
               order_ff <= (req_ff.seg_end != '0) && (req_ff.seg_end <= req_ff.seg_start);
               zero_ff  <= (req_ff.seg_start == '0) && (req_ff.seg_end == '0)
                           && (entry_count_ff != '0);
               full_ff  <= (entry_count_ff >= CW'(MAX_SEGMENTS));
            end
            RESOLVE: begin
               if (resolve_go) begin
                  state_ff <= accept ? EVAL : IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase

         if (resolve_go) begin
            rsp_valid_ff     <= 1'b1;
            rsp_status_ff    <= res_status;
            rsp_found_ff     <= res_found;
            rsp_position_ff  <= PW'(res_pos);
            rsp_seg_id_ff    <= res_entry.seg_id;
            rsp_seg_start_ff <= res_entry.seg_start;
            rsp_seg_end_ff   <= res_entry.seg_end;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (do_insert) begin
            entry_count_ff <= entry_count_ff + CW'(1);
            next_id_ff     <= next_id_ff + DW'(1);
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_position  = rsp_position_ff;
   assign rsp_seg_id    = rsp_seg_id_ff;
   assign rsp_seg_start = rsp_seg_start_ff;
   assign rsp_seg_end   = rsp_seg_end_ff;

   // The table never holds more entries than it has cells.
   `TST_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, entry_count_ff <= CW'(MAX_SEGMENTS))
   // Every insert grows the table by exactly one entry.
   `TST_ASSERT_NXT(a_insert_grows, clock, reset, do_insert, entry_count_ff == $past(entry_count_ff) + CW'(1))
   // A lookup match always lies inside the filled part of the chain.
   `TST_ASSERT_IMP(a_hit_in_table, clock, reset, resolve_go && req_ff.cmd == tst_pkg::CMD_LOOKUP && ev_any, CW'(ev_idx) < entry_count_ff)
   // A resolved item always shows up at the output stage.
   `TST_ASSERT_NXT(a_result_follows, clock, reset, resolve_go, rsp_valid_ff)

endmodule

`default_nettype wire

[tb/time_segment_table_tb.sv]
// Self-checking testbench for time_segment_table: directed and random adds and lookups,
// checked against a mirror of the segment table kept here.
// Depends on tst_pkg and the time_segment_table RTL.
module time_segment_table_tb;

   localparam int TIME_W = tst_pkg::TIME_W;
   localparam int ID_W   = tst_pkg::ID_W;
   localparam int POS_W  = tst_pkg::POS_W;
   localparam int STAT_W = tst_pkg::STAT_W;
   localparam int FROM_W = tst_pkg::FROM_W;
   localparam int TABLE_DEPTH = tst_pkg::MAX_SEGMENTS_DEF;
   localparam int CYCLE_LIMIT = 200000;
   localparam logic [TIME_W-1:0] T_MAX = '1;

   // One expected result transfer.
   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic              found;
      logic [POS_W-1:0]  position;
      logic [ID_W-1:0]   seg_id;
      logic [TIME_W-1:0] seg_start;
      logic [TIME_W-1:0] seg_end;
   } seg_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_cmd = tst_pkg::CMD_ADD;
   logic [TIME_W-1:0]   req_seg_start_in = '0;
   logic [TIME_W-1:0]   req_seg_end_in = '0;
   logic [TIME_W-1:0]   req_elapsed = '0;
   logic [FROM_W-1:0]   req_from_position = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [STAT_W-1:0]   rsp_status;
   logic                rsp_found;
   logic [POS_W-1:0]    rsp_position;
   logic [ID_W-1:0]     rsp_seg_id;
   logic [TIME_W-1:0]   rsp_seg_start;
   logic [TIME_W-1:0]   rsp_seg_end;

   // Mirror of the segment table, updated at each request transfer.
   logic [TIME_W-1:0]   seg_starts [TABLE_DEPTH];
   logic [TIME_W-1:0]   seg_ends [TABLE_DEPTH];
   logic [ID_W-1:0]     seg_ids [TABLE_DEPTH];
   int unsigned         seg_count = 0;
   logic [ID_W-1:0]     id_next = '0;

   seg_result_type      pending_results [$];
   seg_result_type      want;
   int                  mismatch_count = 0;
   int                  cycle_count = 0;
   bit                  send_gaps = 1'b1;
   bit                  rsp_stalls = 1'b1;
   int                  rsp_hold = 0;

   time_segment_table dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_seg_start_in  (req_seg_start_in),
      .req_seg_end_in    (req_seg_end_in),
      .req_elapsed       (req_elapsed),
      .req_from_position (req_from_position),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_found         (rsp_found),
      .rsp_position      (rsp_position),
      .rsp_seg_id        (rsp_seg_id),
      .rsp_seg_start     (rsp_seg_start),
      .rsp_seg_end       (rsp_seg_end)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Applies one request to the mirror table and returns the result it causes.
   function automatic seg_result_type table_response(input logic cmd,
         input logic [TIME_W-1:0] s, input logic [TIME_W-1:0] e,
         input logic [TIME_W-1:0] el, input logic [FROM_W-1:0] from_pos);
      seg_result_type    r;
      logic [TIME_W-1:0] ns;
      logic [TIME_W-1:0] ne;
      logic [TIME_W-1:0] es;
      logic [TIME_W-1:0] ee;
      logic [STAT_W-1:0] st;
      int unsigned       pos;
      int unsigned       i;
      r = '0;
      if (cmd == tst_pkg::CMD_ADD) begin
         ns = s;
         ne = e;
         pos = seg_count;
         st = tst_pkg::STAT_OK;
         if (e != 0 && e <= s) begin
            st = tst_pkg::STAT_ORDER;
         end else if (s == 0 && e == 0 && seg_count > 0) begin
            st = tst_pkg::STAT_ZERO;
         end else if (seg_count >= TABLE_DEPTH) begin
            st = tst_pkg::STAT_FULL;
         end else begin
            // Walk the entries in order until the segment finds its place.
            for (i = 0; i < seg_count; i++) begin
               es = seg_starts[i];
               ee = seg_ends[i];
               if (es == 0 && ee == 0) begin
                  st = tst_pkg::STAT_OVERLAP;
                  break;
               end
               if (ns == 0 && es != 0) begin
                  if (ne >= es) st = tst_pkg::STAT_OVERLAP;
                  pos = i;
                  break;
               end
               if (s == 0) begin
                  // An open start slides to the end of each entry it passes.
                  if (ne <= ee) begin
                     st = tst_pkg::STAT_OVERLAP;
                     break;
                  end
                  ns = ee;
               end else begin
                  if (ns < es) begin
                     if (ne == 0) ne = es;
                     else if (ne > es) st = tst_pkg::STAT_OVERLAP;
                     pos = i;
                     break;
                  end
                  if (ns < ee || ee == 0) begin
                     st = tst_pkg::STAT_OVERLAP;
                     break;
                  end
               end
            end
         end
         if (st == tst_pkg::STAT_OK) begin
            // Shift the tail right by one and insert.
            for (i = seg_count; i > pos; i--) begin
               seg_starts[i] = seg_starts[i-1];
               seg_ends[i] = seg_ends[i-1];
               seg_ids[i] = seg_ids[i-1];
            end
            seg_starts[pos] = ns;
            seg_ends[pos] = ne;
            seg_ids[pos] = id_next;
            seg_count++;
            r.found = 1'b1;
            r.position = pos[POS_W-1:0];
            r.seg_id = id_next;
            r.seg_start = ns;
            r.seg_end = ne;
            id_next = id_next + 1'b1;
         end else begin
            r.status = st;
         end
      end else begin
         // Lookup: first entry from the given position that holds the time.
         for (i = from_pos; i < seg_count; i++) begin
            es = seg_starts[i];
            ee = seg_ends[i];
            if ((es == 0 || el >= es) && (ee == 0 || el < ee)) begin
               r.found = 1'b1;
               r.position = i[POS_W-1:0];
               r.seg_id = seg_ids[i];
               r.seg_start = es;
               r.seg_end = ee;
               break;
            end
         end
      end
      return r;
   endfunction

   function automatic logic [TIME_W-1:0] random_time();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      return w[TIME_W-1:0];
   endfunction

   // A time at or next to a start or end already in the table.
   function automatic logic [TIME_W-1:0] boundary_time();
      logic [TIME_W-1:0] t;
      int unsigned       idx;
      if (seg_count == 0) return $urandom_range(0, 10000);
      idx = $urandom_range(0, seg_count - 1);
      t = $urandom_range(0, 1) ? seg_starts[idx] : seg_ends[idx];
      case ($urandom_range(0, 2))
         0: if (t != 0) t = t - 1'b1;
         1: if (t != T_MAX) t = t + 1'b1;
         default: ;
      endcase
      return t;
   endfunction

   task automatic check_field(input string name, input logic [63:0] exp_val,
         input logic [63:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
         mismatch_count++;
      end
   endtask

   // Predict on each request transfer; compare each result transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $error("result transfer with no request outstanding");
               mismatch_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("found", want.found, rsp_found);
               check_field("position", want.position, rsp_position);
               check_field("seg_id", want.seg_id, rsp_seg_id);
               check_field("seg_start", want.seg_start, rsp_seg_start);
               check_field("seg_end", want.seg_end, rsp_seg_end);
            end
         end
         if (req_valid && req_ready) begin
            pending_results.push_back(table_response(req_cmd, req_seg_start_in,
               req_seg_end_in, req_elapsed, req_from_position));
         end
      end
   end

   // Result side: random stalls, plus a long hold-off when one is requested.
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold = rsp_hold - 1;
      end else if (rsp_stalls) begin
         rsp_ready <= ($urandom_range(0, 99) >= 25);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Guard against a hung handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Offer one item and hold it until its transfer.
   task automatic send_item(input logic cmd, input logic [TIME_W-1:0] s,
         input logic [TIME_W-1:0] e, input logic [TIME_W-1:0] el,
         input logic [FROM_W-1:0] from_pos);
      if (send_gaps) begin
         while ($urandom_range(0, 99) < 25) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_seg_start_in <= s;
      req_seg_end_in <= e;
      req_elapsed <= el;
      req_from_position <= from_pos;
      do @(posedge clock); while (!req_ready);
   endtask

   // Fields that the command ignores still carry random values.
   task automatic send_add(input logic [TIME_W-1:0] s, input logic [TIME_W-1:0] e);
      send_item(tst_pkg::CMD_ADD, s, e, random_time(), FROM_W'($urandom_range(0, 15)));
   endtask

   task automatic send_lookup(input logic [TIME_W-1:0] el, input logic [FROM_W-1:0] from_pos);
      send_item(tst_pkg::CMD_LOOKUP, random_time(), random_time(), el, from_pos);
   endtask

   // Stop offering and wait until every outstanding result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic test_empty_table();
      send_lookup('0, 0);
      send_lookup(T_MAX, 15);
   endtask

   task automatic test_rejected_order();
      send_add(100, 100);
      send_add(T_MAX, 1);
      send_add(T_MAX, T_MAX);
   endtask

   // A whole-time entry is never created: with a single reset it would leave
   // the table at one entry for the rest of the run.
   task automatic test_open_start();
      send_add(5000, 6000);
      send_add(0, 0);
      send_add(0, 5000);
      send_add(0, 1000);
      send_add(0, 800);
      send_add(0, 7000);
   endtask

   task automatic test_bounded_start();
      send_add(2000, 0);
      send_add(1500, 2500);
      send_add(1500, 2000);
      send_add(5500, 5800);
   endtask

   // Segments at the top of the time range, including an open-ended tail.
   task automatic test_extreme_times();
      send_add(T_MAX - 1'b1, T_MAX);
      send_add(9000, 0);
      send_add(T_MAX, 0);
      send_add(T_MAX, 0);
   endtask

   task automatic test_lookup_scan();
      send_lookup(0, 0);
      send_lookup(999, 0);
      send_lookup(1000, 0);
      send_lookup(5000, 0);
      send_lookup(T_MAX, 0);
      send_lookup(500, 1);
      send_lookup(0, 8);
      send_lookup(T_MAX, 15);
   endtask

   // The result side holds off long enough for the block to stall its input.
   task automatic test_result_backpressure();
      int k;
      rsp_hold = 100;
      for (k = 0; k < 20; k++) send_lookup(boundary_time(), 0);
   endtask

   task automatic test_pause_until_idle();
      int k;
      for (k = 0; k < 4; k++) send_lookup(boundary_time(), FROM_W'($urandom_range(0, 15)));
      drain_results();
      for (k = 0; k < 4; k++) send_add(boundary_time(), 0);
   endtask

   // Mostly well-formed adds that fit gaps and lookups near segment edges,
   // with some arbitrary values mixed in.
   task automatic test_random_traffic(input int n_items);
      int                k;
      int unsigned       idx;
      logic [TIME_W-1:0] s;
      logic [TIME_W-1:0] e;
      logic [TIME_W-1:0] el;
      logic [FROM_W-1:0] from_pos;
      for (k = 0; k < n_items; k++) begin
         // A stretch in the middle runs with no idling on either side.
         if (k == n_items / 3) begin
            send_gaps = 1'b0;
            rsp_stalls = 1'b0;
         end else if (k == n_items / 3 + 200) begin
            send_gaps = 1'b1;
            rsp_stalls = 1'b1;
         end
         if ($urandom_range(0, 99) < 55) begin
            case ($urandom_range(0, 3))
               0: el = boundary_time();
               1: el = $urandom_range(0, 20000);
               2: el = random_time();
               default: el = $urandom_range(0, 1) ? T_MAX : '0;
            endcase
            from_pos = $urandom_range(0, 1) ? '0 : FROM_W'($urandom_range(0, 15));
            send_lookup(el, from_pos);
         end else begin
            case ($urandom_range(0, 4))
               0, 1: begin
                  // Start just after an existing end.
                  idx = (seg_count == 0) ? 0 : $urandom_range(0, seg_count - 1);
                  s = (seg_count == 0) ? '0 : seg_ends[idx];
                  s = s + $urandom_range(0, 300);
                  e = ($urandom_range(0, 2) == 0) ? '0 : s + $urandom_range(1, 400);
               end
               2: begin
                  s = '0;
                  e = boundary_time();
               end
               3: begin
                  s = boundary_time();
                  e = $urandom_range(0, 1) ? '0 : boundary_time();
               end
               default: begin
                  s = random_time();
                  e = random_time();
               end
            endcase
            send_add(s, e);
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_rejected_order();
      test_open_start();
      test_bounded_start();
      test_extreme_times();
      test_lookup_scan();
      test_result_backpressure();
      test_pause_until_idle();
      test_random_traffic(1000);
      drain_results();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
